// ===== rtl/wts_pkg.sv =====
// Shared types and constants for the wave-table sound channel.
// No dependencies; imported by the wave memory, the channel top and the testbench.
package wts_pkg;

  localparam int WAVE_BYTES  = 16;
  localparam int WAVE_AW     = $clog2(WAVE_BYTES);
  localparam int START_DELAY = 6;
  localparam int READ_HOLD   = 2;
  localparam int COUNT_W     = 14;
  localparam int PERIOD_W    = 13;
  localparam int WINDOW_W    = 8;

  // transaction kinds on the input stream
  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_REG_WR  = 3'd1,
    MODE_REG_RD  = 3'd2,
    MODE_WAVE_WR = 3'd3,
    MODE_WAVE_RD = 3'd4,
    MODE_PWR_OFF = 3'd5,
    MODE_PWR_ON  = 3'd6
  } mode_t;

  // register indexes
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_LENGTH  = 3'd1;
  localparam logic [2:0] REG_VOLUME  = 3'd2;
  localparam logic [2:0] REG_FREQ_LO = 3'd3;
  localparam logic [2:0] REG_FREQ_HI = 3'd4;

  typedef enum logic [1:0] {
    LOCK_NORMAL = 2'd0,
    LOCK_SINGLE = 2'd1,
    LOCK_NONE   = 2'd2
  } lock_t;

  // one write and one read port per cycle
  typedef struct packed {
    logic               we;
    logic [WAVE_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [WAVE_AW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/wts_wave_mem.sv =====
// Wave memory: 16 bytes, one write and one registered read per cycle.
// Per-byte valid flags give the power-up pattern without a clearing pass.
// Depends on wts_pkg.
module wts_wave_mem
  import wts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0]         mem [WAVE_BYTES];
  logic [WAVE_BYTES-1:0] valid_r;
  logic [7:0]         q_r;
  logic               q_valid_r;
  logic               q_odd_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    q_r     <= mem[req.raddr];
    q_odd_r <= req.raddr[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= valid_r[req.raddr];
      if (req.we) begin
        valid_r[req.waddr] <= 1'b1;
      end
    end
  end

  // unwritten bytes read as 0x00 (even) / 0xff (odd)
  assign rdata = q_valid_r ? q_r : {8{q_odd_r}};

endmodule

// ===== rtl/wave_table_sound_channel.sv =====
// Wave-table sound channel: one result per input transaction, one transaction in work at a time.
// Path to out_tvalid: register, power and wave-write items go straight to DONE, an unlocked wave
// read passes WRD, a trigger inside a read window passes COPY (byte copies through the memory port),
// and a playing tick batch runs LOOP (one period wrap per step) and FETCH if it wrapped; DONE waits
// out any output stall. in_tready returns at the edge that loads the result, so items do not overlap.
// Reset (rst_n low, synchronous) clears control state; wave bytes read 0x00/0xff until written.
module wave_table_sound_channel
  import wts_pkg::*;
#(
  parameter int START_CYCLES = START_DELAY,
  parameter int HOLD_CYCLES  = READ_HOLD
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [5:0]  in_tuser,   // mode[2:0], reg_select[5:3]
  input  logic [23:0] in_tdata,   // wave_addr[3:0], data[11:4], ticks[17:12],
                                  // zero pad[23:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // level[3:0], read_data[11:4], channel_on[12],
                                  // dac_on[13], zero pad[15:14]
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOOP  = 6'b000010,
    ST_FETCH = 6'b000100,
    ST_COPY  = 6'b001000,
    ST_WRD   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  logic [2:0]         in_mode;
  logic [2:0]         in_sel;
  logic [WAVE_AW-1:0] in_addr;
  logic [7:0]         in_data;
  logic [5:0]         in_ticks;

  assign in_mode  = in_tuser[2:0];
  assign in_sel   = in_tuser[5:3];
  assign in_addr  = in_tdata[3:0];
  assign in_data  = in_tdata[11:4];
  assign in_ticks = in_tdata[17:12];

  state_t                     state_r, state_nxt;
  logic [10:0]                freq_r, freq_nxt;
  logic [PERIOD_W-1:0]        period_r, period_nxt;
  logic signed [COUNT_W-1:0]  count_r, count_nxt;
  logic [4:0]                 pos_r, pos_nxt;
  logic [7:0]                 fetched_r, fetched_nxt;
  logic signed [WINDOW_W-1:0] rw_r, rw_nxt;
  logic [2:0]                 shift_r, shift_nxt;
  lock_t                      lock_r, lock_nxt;
  logic                       dac_r, dac_nxt;
  logic                       playing_r, playing_nxt;
  logic                       powered_r, powered_nxt;
  logic                       stop_r, stop_nxt;
  logic                       adjusted_r, adjusted_nxt;
  logic [5:0]                 ticks_r, ticks_nxt;
  logic [7:0]                 rd_r, rd_nxt;
  logic [WAVE_AW-1:0]         copy_src_r, copy_src_nxt;
  logic                       copy_four_r, copy_four_nxt;
  logic [2:0]                 copy_idx_r, copy_idx_nxt;
  logic                       out_tvalid_r, out_tvalid_nxt;
  logic [15:0]                out_tdata_r, out_tdata_nxt;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  // scratch values of the combinational update
  logic [11:0]                freq_diff;
  logic [PERIOD_W-1:0]        new_period;
  logic [4:0]                 next_pos;
  logic signed [WINDOW_W-1:0] rw_left;
  logic [2:0]                 copy_last;
  logic [3:0]                 nibble;
  logic [3:0]                 level;
  logic [1:0]                 vol_code;

  wts_wave_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign nibble    = pos_r[0] ? fetched_r[3:0] : fetched_r[7:4];
  assign level     = shift_r[2] ? 4'd0 : (nibble >> shift_r[1:0]);
  assign vol_code  = shift_r[1:0] + 2'd1;
  assign next_pos  = pos_r + 5'd1;
  assign copy_last = copy_four_r ? 3'd4 : 3'd1;
  assign rw_left   = rw_r - $signed({2'b00, ticks_r});

  always_comb begin
    state_nxt      = state_r;
    freq_nxt       = freq_r;
    period_nxt     = period_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    fetched_nxt    = fetched_r;
    rw_nxt         = rw_r;
    shift_nxt      = shift_r;
    lock_nxt       = lock_r;
    dac_nxt        = dac_r;
    playing_nxt    = playing_r;
    powered_nxt    = powered_r;
    stop_nxt       = stop_r;
    adjusted_nxt   = adjusted_r;
    ticks_nxt      = ticks_r;
    rd_nxt         = rd_r;
    copy_src_nxt   = copy_src_r;
    copy_four_nxt  = copy_four_r;
    copy_idx_nxt   = copy_idx_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    mem_req        = '0;
    freq_diff      = '0;
    new_period     = period_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          rd_nxt    = 8'h00;
          ticks_nxt = in_ticks;
          state_nxt = ST_DONE;
          unique case (in_mode)
            MODE_TICK: begin
              if (period_r == '0 || !playing_r) begin
                lock_nxt = LOCK_NORMAL;
              end else begin
                count_nxt    = count_r - $signed({{(COUNT_W-6){1'b0}}, in_ticks});
                adjusted_nxt = 1'b0;
                state_nxt    = ST_LOOP;
              end
            end
            MODE_REG_WR: begin
              if (powered_r) begin
                unique case (in_sel)
                  REG_CTRL: begin
                    if (!in_data[7]) begin
                      playing_nxt = 1'b0;
                      dac_nxt     = 1'b0;
                      lock_nxt    = LOCK_NORMAL;
                    end else begin
                      dac_nxt   = 1'b1;
                      lock_nxt  = LOCK_NONE;
                      count_nxt = $signed({1'b0, period_r});
                    end
                  end
                  REG_VOLUME: begin
                    shift_nxt = (in_data[6:5] == 2'd0) ? 3'd4 : {1'b0, in_data[6:5] - 2'd1};
                  end
                  REG_FREQ_LO: begin
                    freq_nxt   = {freq_r[10:8], in_data};
                    freq_diff  = 12'd2048 - {1'b0, freq_nxt};
                    new_period = {freq_diff, 1'b0};
                    period_nxt = new_period;
                  end
                  REG_FREQ_HI: begin
                    freq_nxt   = {in_data[2:0], freq_r[7:0]};
                    freq_diff  = 12'd2048 - {1'b0, freq_nxt};
                    new_period = {freq_diff, 1'b0};
                    period_nxt = new_period;
                    stop_nxt   = in_data[6];
                    if (in_data[7]) begin
                      // trigger inside a read window corrupts the first bytes
                      if (rw_r > 0 && dac_r) begin
                        lock_nxt      = LOCK_NORMAL;
                        copy_four_nxt = |next_pos[4:3];
                        copy_src_nxt  = (|next_pos[4:3]) ? {next_pos[4:3], 2'b00}
                                                         : next_pos[4:1];
                        copy_idx_nxt  = 3'd0;
                        state_nxt     = ST_COPY;
                      end
                      rw_nxt      = '0;
                      pos_nxt     = '0;
                      count_nxt   = $signed({1'b0, new_period}) +
                                    $signed(COUNT_W'(START_CYCLES));
                      playing_nxt = dac_r;
                    end
                  end
                  default: begin
                  end
                endcase
              end
            end
            MODE_REG_RD: begin
              unique case (in_sel)
                REG_CTRL:    rd_nxt = {dac_r, 7'h7f};
                REG_VOLUME:  rd_nxt = shift_r[2] ? 8'h9f : {1'b1, vol_code, 5'h1f};
                REG_FREQ_HI: rd_nxt = {1'b1, stop_r, 6'h3f};
                default:     rd_nxt = 8'hff;
              endcase
            end
            MODE_WAVE_WR: begin
              unique case (lock_r)
                LOCK_NORMAL: begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = in_addr;
                  mem_req.wdata = in_data;
                end
                LOCK_SINGLE: begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = pos_r[4:1];
                  mem_req.wdata = in_data;
                end
                default: begin
                end
              endcase
            end
            MODE_WAVE_RD: begin
              unique case (lock_r)
                LOCK_NORMAL: begin
                  mem_req.raddr = in_addr;
                  state_nxt     = ST_WRD;
                end
                LOCK_SINGLE: rd_nxt = fetched_r;
                default:     rd_nxt = 8'hff;
              endcase
            end
            MODE_PWR_OFF: begin
              pos_nxt = '0;
              if (powered_r) begin
                dac_nxt    = 1'b0;
                lock_nxt   = LOCK_NORMAL;
                shift_nxt  = 3'd4;
                freq_nxt   = '0;
                period_nxt = PERIOD_W'(4096);
                stop_nxt   = 1'b0;
              end
              playing_nxt = 1'b0;
              powered_nxt = 1'b0;
            end
            MODE_PWR_ON: powered_nxt = 1'b1;
            default: begin
            end
          endcase
        end
      end

      // one period wrap per cycle
      ST_LOOP: begin
        if (count_r <= 0) begin
          pos_nxt      = next_pos;
          lock_nxt     = LOCK_SINGLE;
          rw_nxt       = $signed(count_r[WINDOW_W-1:0]) + $signed(WINDOW_W'(HOLD_CYCLES));
          adjusted_nxt = 1'b1;
          count_nxt    = count_r + $signed({1'b0, period_r});
        end else begin
          mem_req.raddr = pos_r[4:1];
          if (adjusted_r) begin
            if (rw_r <= 0) begin
              lock_nxt = LOCK_NONE;
            end
            state_nxt = ST_FETCH;
          end else begin
            if (rw_r > 0) begin
              rw_nxt = rw_left;
              if (rw_left <= 0) begin
                lock_nxt = LOCK_NONE;
              end
            end else begin
              lock_nxt = LOCK_NONE;
            end
            state_nxt = ST_DONE;
          end
        end
      end

      ST_FETCH: begin
        fetched_nxt = mem_rdata;
        state_nxt   = ST_DONE;
      end

      // read source k while writing source k-1 into byte k-1
      ST_COPY: begin
        if (copy_idx_r < copy_last) begin
          mem_req.raddr = copy_src_r + {2'b00, copy_idx_r[1:0]};
        end
        if (copy_idx_r != 3'd0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = {2'b00, copy_idx_r[1:0] - 2'd1};
          mem_req.wdata = mem_rdata;
        end
        copy_idx_nxt = copy_idx_r + 3'd1;
        if (copy_idx_r == copy_last) begin
          state_nxt = ST_DONE;
        end
      end

      ST_WRD: begin
        rd_nxt    = mem_rdata;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, dac_r, playing_r, rd_r, level};
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      freq_r       <= '0;
      period_r     <= '0;
      count_r      <= '0;
      pos_r        <= '0;
      fetched_r    <= '0;
      rw_r         <= '0;
      shift_r      <= 3'd4;
      lock_r       <= LOCK_NORMAL;
      dac_r        <= 1'b0;
      playing_r    <= 1'b0;
      powered_r    <= 1'b1;
      stop_r       <= 1'b0;
      adjusted_r   <= 1'b0;
      copy_idx_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      freq_r       <= freq_nxt;
      period_r     <= period_nxt;
      count_r      <= count_nxt;
      pos_r        <= pos_nxt;
      fetched_r    <= fetched_nxt;
      rw_r         <= rw_nxt;
      shift_r      <= shift_nxt;
      lock_r       <= lock_nxt;
      dac_r        <= dac_nxt;
      playing_r    <= playing_nxt;
      powered_r    <= powered_nxt;
      stop_r       <= stop_nxt;
      adjusted_r   <= adjusted_nxt;
      copy_idx_r   <= copy_idx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ticks_r     <= ticks_nxt;
    rd_r        <= rd_nxt;
    copy_src_r  <= copy_src_nxt;
    copy_four_r <= copy_four_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

// ===== rtl/wts_checker.sv =====
// Port-level checks for the wave-table sound channel, bound to the top level.
// Sees only the top-level ports; no package needed.
module wts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while busy");

  // playing never outlives the converter
  a_play_dac: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[12] && !out_tdata[13]))
    else $error("channel_on without dac_on");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:14] == 2'b00)
    else $error("pad bits set");

endmodule

bind wave_table_sound_channel wts_checker u_wts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/tb_wave_table_sound_channel.sv =====
// Self-checking testbench for wave_table_sound_channel: directed and random transactions,
// each result checked against a behavioural prediction of the channel kept in this file.
// Depends on rtl/wts_pkg.sv and rtl/wave_table_sound_channel.sv.
module tb_wave_table_sound_channel;
  import wts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT     = 200000;
  localparam int         TAIL_CYCLES     = 64;
  localparam int         REPORT_CAP      = 40;
  localparam logic [2:0] MODE_SPARE      = 3'd7;
  localparam logic [2:0] REG_SPARE_FIRST = REG_FREQ_HI + 3'd1;

  typedef struct {
    logic [2:0] mode;
    logic [2:0] sel;
    logic [3:0] addr;
    logic [7:0] data;
    logic [5:0] ticks;
  } chan_cmd_t;

  typedef struct {
    logic [3:0] level;
    logic [7:0] rdata;
    logic       ch_on;
    logic       dac_on;
  } chan_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [5:0]  in_tuser;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  // predicted channel state
  logic [7:0]  wave_mem [WAVE_BYTES];
  logic [10:0] freq;
  logic [12:0] period;
  int          tcount;
  logic [4:0]  pos;
  logic [7:0]  fetched;
  int          rwin;
  logic [2:0]  vshift;
  lock_t       lock;
  logic        dac;
  logic        playing;
  logic        powered;
  logic        stop_bit;

  chan_result_t pending_results[$];
  bit           no_gaps;
  int           errors;
  int           sent_cnt;
  int           checked_cnt;
  int           pointer_steps;
  int           trigger_copies;
  int           cycle_cnt;

  wave_table_sound_channel u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [12:0] period_of(logic [10:0] f);
    return 13'((2048 - int'(f)) * 2);
  endfunction

  function automatic void write_channel_reg(logic [2:0] sel, logic [7:0] v);
    logic [4:0] p;
    logic [3:0] base;
    int         i;
    if (!powered) return;
    case (sel)
      REG_CTRL: begin
        if (!v[7]) begin
          playing = 1'b0;
          dac     = 1'b0;
          lock    = LOCK_NORMAL;
        end else begin
          dac    = 1'b1;
          lock   = LOCK_NONE;
          tcount = int'(period);
        end
      end
      REG_VOLUME: vshift = (v[6:5] == 2'd0) ? 3'd4 : 3'(v[6:5] - 2'd1);
      REG_FREQ_LO: begin
        freq[7:0] = v;
        period    = period_of(freq);
      end
      REG_FREQ_HI: begin
        freq[10:8] = v[2:0];
        period     = period_of(freq);
        stop_bit   = v[6];
        if (v[7]) begin
          // trigger landing in a read window copies the byte(s) being read to the front
          if (rwin > 0 && dac) begin
            p    = pos + 5'd1;
            lock = LOCK_NORMAL;
            trigger_copies++;
            if (p < 5'd8) begin
              wave_mem[0] = wave_mem[p[4:1]];
            end else begin
              base = {p[4:3], 2'b00};
              for (i = 0; i < 4; i++) wave_mem[i] = wave_mem[base + 4'(i)];
            end
          end
          rwin    = 0;
          pos     = 5'd0;
          tcount  = int'(period) + START_DELAY;
          playing = dac;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic chan_result_t predict_channel(chan_cmd_t c);
    chan_result_t r;
    logic         adjusted;
    logic [3:0]   nib;
    r.rdata  = 8'h00;
    adjusted = 1'b0;
    case (c.mode)
      MODE_TICK: begin
        if (period == 13'd0 || !playing) begin
          lock = LOCK_NORMAL;
        end else begin
          tcount -= int'(c.ticks);
          while (tcount <= 0) begin
            pos      = pos + 5'd1;
            fetched  = wave_mem[pos[4:1]];
            lock     = LOCK_SINGLE;
            rwin     = READ_HOLD + tcount;
            adjusted = 1'b1;
            tcount  += int'(period);
            pointer_steps++;
          end
          if (!adjusted && rwin > 0) begin
            rwin -= int'(c.ticks);
            if (rwin <= 0) lock = LOCK_NONE;
          end else if (rwin <= 0) begin
            lock = LOCK_NONE;
          end
        end
      end
      MODE_REG_WR: write_channel_reg(c.sel, c.data);
      MODE_REG_RD: begin
        case (c.sel)
          REG_CTRL:    r.rdata = {dac, 7'h7f};
          REG_VOLUME:  r.rdata = (vshift >= 3'd4 ? 8'h00 : {1'b0, 2'(vshift + 3'd1), 5'h00})
                                 | 8'h9f;
          REG_FREQ_HI: r.rdata = {1'b1, stop_bit, 6'h3f};
          default:     r.rdata = 8'hff;
        endcase
      end
      MODE_WAVE_WR: begin
        if (lock == LOCK_NORMAL) wave_mem[c.addr] = c.data;
        else if (lock == LOCK_SINGLE) wave_mem[pos[4:1]] = c.data;
      end
      MODE_WAVE_RD: begin
        if (lock == LOCK_NORMAL) r.rdata = wave_mem[c.addr];
        else if (lock == LOCK_SINGLE) r.rdata = fetched;
        else r.rdata = 8'hff;
      end
      MODE_PWR_OFF: begin
        pos = 5'd0;
        if (powered) begin
          write_channel_reg(REG_CTRL, 8'h00);
          write_channel_reg(REG_LENGTH, 8'h00);
          write_channel_reg(REG_VOLUME, 8'h00);
          write_channel_reg(REG_FREQ_LO, 8'h00);
          write_channel_reg(REG_FREQ_HI, 8'h00);
        end
        playing = 1'b0;
        powered = 1'b0;
      end
      MODE_PWR_ON: powered = 1'b1;
      default: ;
    endcase
    nib      = pos[0] ? fetched[3:0] : fetched[7:4];
    r.level  = (vshift >= 3'd4) ? 4'd0 : nib >> vshift;
    r.ch_on  = playing;
    r.dac_on = dac;
    return r;
  endfunction

  task automatic send_cmd(input logic [2:0] mode, input logic [2:0] sel,
                          input logic [3:0] addr, input logic [7:0] data,
                          input logic [5:0] ticks);
    chan_cmd_t c;
    c = '{mode, sel, addr, data, ticks};
    if (!no_gaps && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {sel, mode};
    in_tdata  <= {6'd0, ticks, data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_channel(c));
    sent_cnt++;
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      if (errors < REPORT_CAP)
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // result side: check each transaction, then decide whether to stall
  always @(posedge clk) begin
    chan_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none, got 0x%0h",
                 $time, out_tdata);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        report_field("level", exp_r.level, out_tdata[3:0]);
        report_field("read_data", exp_r.rdata, out_tdata[11:4]);
        report_field("channel_on", exp_r.ch_on, out_tdata[12]);
        report_field("dac_on", exp_r.dac_on, out_tdata[13]);
        checked_cnt++;
      end
    end
    out_tready <= no_gaps || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t ns: timed out with %0d results outstanding", $time, pending_results.size());
      $display("tb_wave_table_sound_channel: done, errors");
      $finish;
    end
  end

  task automatic test_reset_state();
    send_cmd(MODE_REG_RD, REG_CTRL, 4'h0, 8'h00, 6'd0);
    send_cmd(MODE_REG_RD, REG_LENGTH, 4'h0, 8'h00, 6'd0);
    send_cmd(MODE_REG_RD, REG_VOLUME, 4'h0, 8'h00, 6'd0);
    send_cmd(MODE_REG_RD, REG_FREQ_HI, 4'h0, 8'h00, 6'd0);
    send_cmd(MODE_REG_RD, 3'd7, 4'h0, 8'h00, 6'd0);
    send_cmd(MODE_WAVE_RD, 3'd0, 4'h0, 8'h00, 6'd0);
    send_cmd(MODE_WAVE_RD, 3'd0, 4'hf, 8'h00, 6'd0);
    // idle tick batch: no period yet
    send_cmd(MODE_TICK, 3'd0, 4'h0, 8'h00, 6'd63);
    send_cmd(MODE_SPARE, 3'd7, 4'hf, 8'hff, 6'd63);
  endtask

  task automatic test_register_writes();
    send_cmd(MODE_REG_WR, REG_VOLUME, 4'h0, 8'hff, 6'd0);
    send_cmd(MODE_REG_WR, REG_FREQ_LO, 4'h0, 8'hff, 6'd0);
    send_cmd(MODE_REG_WR, REG_FREQ_HI, 4'h0, 8'h47, 6'd0);
    send_cmd(MODE_WAVE_WR, 3'd0, 4'hf, 8'ha5, 6'd0);
    send_cmd(MODE_REG_WR, REG_CTRL, 4'h0, 8'h80, 6'd0);
    // converter on: wave memory blocked
    send_cmd(MODE_WAVE_RD, 3'd0, 4'h3, 8'h00, 6'd0);
  endtask

  task automatic test_playback_window();
    send_cmd(MODE_REG_WR, REG_FREQ_HI, 4'h0, 8'hc7, 6'd0);
    send_cmd(MODE_TICK, 3'd0, 4'h0, 8'h00, 6'd7);
    send_cmd(MODE_TICK, 3'd0, 4'h0, 8'h00, 6'd1);
    send_cmd(MODE_WAVE_RD, 3'd0, 4'h9, 8'h00, 6'd0);
    send_cmd(MODE_WAVE_WR, 3'd0, 4'h9, 8'h3c, 6'd0);
  endtask

  task automatic test_trigger_copy();
    // first a single-byte copy, then a four-byte group copy after seven steps
    send_cmd(MODE_REG_WR, REG_FREQ_HI, 4'h0, 8'h87, 6'd0);
    send_cmd(MODE_TICK, 3'd0, 4'h0, 8'h00, 6'd21);
    send_cmd(MODE_REG_WR, REG_FREQ_HI, 4'h0, 8'h87, 6'd0);
    send_cmd(MODE_WAVE_RD, 3'd0, 4'h0, 8'h00, 6'd0);
  endtask

  task automatic test_power_cycle();
    send_cmd(MODE_PWR_OFF, 3'd0, 4'h0, 8'h00, 6'd0);
    send_cmd(MODE_REG_WR, REG_CTRL, 4'h0, 8'h80, 6'd0);
    send_cmd(MODE_REG_RD, REG_CTRL, 4'h0, 8'h00, 6'd0);
    send_cmd(MODE_PWR_ON, 3'd0, 4'h0, 8'h00, 6'd0);
  endtask

  task automatic start_playback();
    logic [7:0] lo;
    lo = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'he0, 8'hff));
    send_cmd(MODE_PWR_ON, 3'($urandom), 4'($urandom), 8'($urandom), 6'($urandom));
    send_cmd(MODE_REG_WR, REG_CTRL, 4'($urandom), 8'h80 | 8'($urandom), 6'($urandom));
    send_cmd(MODE_REG_WR, REG_VOLUME, 4'($urandom), 8'($urandom), 6'($urandom));
    send_cmd(MODE_REG_WR, REG_FREQ_LO, 4'($urandom), lo, 6'($urandom));
    send_cmd(MODE_REG_WR, REG_FREQ_HI, 4'($urandom), {1'b1, 4'($urandom), 3'd7},
             6'($urandom));
  endtask

  task automatic play_random_item();
    int         r;
    logic [2:0] sel;
    logic [3:0] addr;
    logic [7:0] data;
    logic [5:0] ticks;
    r     = $urandom_range(0, 99);
    sel   = 3'($urandom);
    addr  = 4'($urandom);
    data  = 8'($urandom);
    ticks = 6'($urandom);
    if (r < 40) begin
      case ($urandom_range(0, 9))
        0:       ticks = 6'($urandom_range(0, 63));
        1, 2:    ticks = 6'($urandom_range(0, 15));
        default: ticks = 6'($urandom_range(0, 4));
      endcase
      send_cmd(MODE_TICK, sel, addr, data, ticks);
    end else if (r < 52) begin
      // mostly triggers at a short period
      if ($urandom_range(0, 3) != 0) data[2:0] = 3'd7;
      if ($urandom_range(0, 9) < 7) data[7] = 1'b1;
      send_cmd(MODE_REG_WR, REG_FREQ_HI, addr, data, ticks);
    end else if (r < 57) begin
      send_cmd(MODE_REG_WR, sel, addr, data, ticks);
    end else if (r < 64) begin
      send_cmd(MODE_REG_RD, sel, addr, data, ticks);
    end else if (r < 76) begin
      send_cmd(MODE_WAVE_WR, sel, addr, data, ticks);
    end else if (r < 92) begin
      send_cmd(MODE_WAVE_RD, sel, addr, data, ticks);
    end else if (r < 94) begin
      send_cmd(MODE_PWR_OFF, sel, addr, data, ticks);
    end else if (r < 97) begin
      send_cmd(MODE_PWR_ON, sel, addr, data, ticks);
    end else if (r < 98) begin
      send_cmd(MODE_SPARE, sel, addr, data, ticks);
    end else begin
      send_cmd(3'($urandom), 3'($urandom_range(REG_SPARE_FIRST, 7)), addr, data, ticks);
    end
  endtask

  task automatic test_random_playback();
    int ep;
    for (ep = 0; ep < 32; ep++) begin
      no_gaps = (ep >= 10 && ep < 17);
      start_playback();
      repeat (17) play_random_item();
      if (ep == 20) wait_results_drained();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tuser       = '0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    no_gaps        = 1'b0;
    errors         = 0;
    sent_cnt       = 0;
    checked_cnt    = 0;
    pointer_steps  = 0;
    trigger_copies = 0;
    cycle_cnt      = 0;
    for (int i = 0; i < WAVE_BYTES; i++) wave_mem[i] = i[0] ? 8'hff : 8'h00;
    freq     = '0;
    period   = '0;
    tcount   = 0;
    pos      = '0;
    fetched  = '0;
    rwin     = 0;
    vshift   = 3'd4;
    lock     = LOCK_NORMAL;
    dac      = 1'b0;
    playing  = 1'b0;
    powered  = 1'b1;
    stop_bit = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_register_writes();
    test_playback_window();
    test_trigger_copy();
    test_power_cycle();
    test_random_playback();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end

    $display("covered %0d transactions, %0d results checked, %0d mismatches",
             sent_cnt, checked_cnt, errors);
    $display("playback stepped the pointer %0d times; %0d triggers copied wave bytes",
             pointer_steps, trigger_copies);
    if (errors == 0) begin
      $display("tb_wave_table_sound_channel: done, clean");
    end else begin
      $display("tb_wave_table_sound_channel: done, errors");
    end
    $finish;
  end

endmodule
